>>> hw/rtl/sirf_pkg.sv
// Shared types and constants for the signed integer radix formatter.
// Used by sirf_ctrl, sirf_dpath and signed_integer_radix_formatter_unit.
package sirf_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int RADIX_WIDTH  = 5;
    localparam int PREFIX_WIDTH = 2;
    localparam int CHAR_WIDTH   = 8;
    localparam int DIGIT_WIDTH  = 4;
    localparam int REM_WIDTH    = DIGIT_WIDTH + 1;

    // The divider retires this many quotient bits per cycle.
    localparam int DIV_BITS    = 8;
    localparam int DIV_CYCLES  = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_WIDTH   = DIV_CYCLES * DIV_BITS;
    localparam int STEP_WIDTH  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
    localparam int STACK_WIDTH = VALUE_WIDTH * DIGIT_WIDTH;

    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(16);

    localparam logic [PREFIX_WIDTH-1:0] PFX_NONE = PREFIX_WIDTH'(0);
    localparam logic [PREFIX_WIDTH-1:0] PFX_BIN  = PREFIX_WIDTH'(1);
    localparam logic [PREFIX_WIDTH-1:0] PFX_HEX  = PREFIX_WIDTH'(2);

    localparam logic [CHAR_WIDTH-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_B    = 8'h62;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X    = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_ALPHA_BASE = 8'h57;

    typedef enum logic [1:0] {
        EMIT_SIGN   = 2'd0,
        EMIT_ZERO   = 2'd1,
        EMIT_LETTER = 2'd2,
        EMIT_DIGIT  = 2'd3
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      div_step;
        logic      push;
        logic      emit;
        emit_sel_t sel;
        logic      last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic neg;
        logic has_prefix;
        logic quot_zero;
        logic one_left;
        logic stack_empty;
        logic slot_free;
    } dp_status_t;

    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
        logic [CHAR_WIDTH-1:0] ext;
        ext = CHAR_WIDTH'(d);
        if (d > DIGIT_WIDTH'(9)) begin
            return CH_ALPHA_BASE + ext;
        end
        return CH_ZERO + ext;
    endfunction

endpackage

>>> hw/rtl/sirf_ctrl.sv
// Controller state machine of the radix formatter.
// Depends on sirf_pkg; drives sirf_dpath through command and status structs.
module sirf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sirf_pkg::dp_status_t status,
    output sirf_pkg::ctrl_cmd_t cmd,
    output logic                idle
);
    import sirf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_PUSH  = 7'b0000100,
        S_SIGN  = 7'b0001000,
        S_PRE0  = 7'b0010000,
        S_PRE1  = 7'b0100000,
        S_DIGIT = 7'b1000000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [STEP_WIDTH-1:0] step_reg;
    logic [STEP_WIDTH-1:0] step_next;

    assign idle = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.sel      = EMIT_DIGIT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_WIDTH'(DIV_CYCLES - 1)) begin
                    step_next  = '0;
                    state_next = S_PUSH;
                end else begin
                    step_next = step_reg + STEP_WIDTH'(1);
                end
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                if (!status.quot_zero) begin
                    state_next = S_DIV;
                end else if (status.neg) begin
                    state_next = S_SIGN;
                end else if (status.has_prefix) begin
                    state_next = S_PRE0;
                end else begin
                    state_next = S_DIGIT;
                end
            end
            S_SIGN:
            begin
                cmd.sel = EMIT_SIGN;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.has_prefix ? S_PRE0 : S_DIGIT;
                end
            end
            S_PRE0:
            begin
                cmd.sel = EMIT_ZERO;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_PRE1;
                end
            end
            S_PRE1:
            begin
                cmd.sel = EMIT_LETTER;
                if (status.slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                cmd.sel = EMIT_DIGIT;
                if (status.slot_free) begin
                    cmd.emit = 1'b1;
                    if (status.one_left) begin
                        cmd.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> hw/rtl/sirf_dpath.sv
// Datapath of the radix formatter: operand registers, shift-subtract divider,
// digit stack and output register. Depends on sirf_pkg.
module sirf_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sirf_pkg::ctrl_cmd_t                    cmd,
    output sirf_pkg::dp_status_t                   status,
    input  logic signed [sirf_pkg::VALUE_WIDTH-1:0] value,
    input  logic [sirf_pkg::RADIX_WIDTH-1:0]       radix,
    input  logic [sirf_pkg::PREFIX_WIDTH-1:0]      prefix_kind,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [sirf_pkg::CHAR_WIDTH-1:0]        char_out,
    output logic                                   last_char
);
    import sirf_pkg::*;

    logic [PAD_WIDTH-1:0]    div_reg;
    logic [PAD_WIDTH-1:0]    div_next;
    logic [DIGIT_WIDTH-1:0]  rem_reg;
    logic [REM_WIDTH-1:0]    rem_next;
    logic [RADIX_WIDTH-1:0]  radix_reg;
    logic [RADIX_WIDTH-1:0]  radix_clamped;
    logic                    neg_reg;
    logic                    has_prefix_reg;
    logic                    hex_reg;
    logic [STACK_WIDTH-1:0]  stack_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic                    out_valid_reg;
    logic [CHAR_WIDTH-1:0]   char_reg;
    logic                    last_reg;
    logic [VALUE_WIDTH-1:0]  magnitude;
    logic [CHAR_WIDTH-1:0]   char_sel;
    logic                    slot_free;

    assign magnitude = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;

    always_comb begin
        if (radix < RADIX_MIN) begin
            radix_clamped = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            radix_clamped = RADIX_MAX;
        end else begin
            radix_clamped = radix;
        end
    end

    always_comb begin
        div_next = div_reg;
        rem_next = REM_WIDTH'(rem_reg);
        for (int i = 0; i < DIV_BITS; i++) begin
            rem_next = {rem_next[DIGIT_WIDTH-1:0], div_next[PAD_WIDTH-1]};
            div_next = {div_next[PAD_WIDTH-2:0], 1'b0};
            if (rem_next >= radix_reg) begin
                rem_next    = rem_next - radix_reg;
                div_next[0] = 1'b1;
            end
        end
    end

    always_comb begin
        case (cmd.sel)
            EMIT_SIGN:   char_sel = CH_MINUS;
            EMIT_ZERO:   char_sel = CH_ZERO;
            EMIT_LETTER: char_sel = hex_reg ? CH_LOWER_X : CH_LOWER_B;
            EMIT_DIGIT:  char_sel = digit_char(stack_reg[DIGIT_WIDTH-1:0]);
            default:     char_sel = CH_ZERO;
        endcase
    end

    assign slot_free = !out_valid_reg || !out_stall;

    assign status.neg         = neg_reg;
    assign status.has_prefix  = has_prefix_reg;
    assign status.quot_zero   = (div_reg == '0);
    assign status.one_left    = (count_reg == COUNT_WIDTH'(1));
    assign status.stack_empty = (count_reg == '0);
    assign status.slot_free   = slot_free;

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            div_reg        <= PAD_WIDTH'(magnitude);
            rem_reg        <= '0;
            radix_reg      <= radix_clamped;
            neg_reg        <= value[VALUE_WIDTH-1];
            has_prefix_reg <= (prefix_kind == PFX_BIN) || (prefix_kind == PFX_HEX);
            hex_reg        <= (prefix_kind == PFX_HEX);
        end else if (cmd.div_step) begin
            div_reg <= div_next;
            rem_reg <= rem_next[DIGIT_WIDTH-1:0];
        end else if (cmd.push) begin
            rem_reg <= '0;
        end
        if (cmd.push) begin
            stack_reg <= {stack_reg[STACK_WIDTH-DIGIT_WIDTH-1:0], rem_reg};
        end else if (cmd.emit && (cmd.sel == EMIT_DIGIT)) begin
            stack_reg <= {{DIGIT_WIDTH{1'b0}}, stack_reg[STACK_WIDTH-1:DIGIT_WIDTH]};
        end
        if (cmd.emit) begin
            char_reg <= char_sel;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                count_reg <= '0;
            end else if (cmd.push) begin
                count_reg <= count_reg + COUNT_WIDTH'(1);
            end else if (cmd.emit && (cmd.sel == EMIT_DIGIT)) begin
                count_reg <= count_reg - COUNT_WIDTH'(1);
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last_char = last_reg;

endmodule

>>> hw/rtl/signed_integer_radix_formatter_unit.sv
// Top level of the signed integer radix formatter.
// Depends on sirf_pkg, sirf_ctrl and sirf_dpath.
//
// Each accepted item is a signed value, a radix and a prefix code; the block
// returns one item per ASCII character: an optional minus sign, an optional
// "0b" or "0x" prefix, then the digits most significant first, with the last
// character marked by last_char. Radix values below 2 act as 2, above 16 act
// as 16, and prefix code 3 acts as no prefix. The digits come from one shared
// shift-subtract divider that retires 8 quotient bits per cycle; each digit
// takes the divide steps of S_DIV and then a push of the remainder onto the
// digit stack in S_PUSH. A new item is taken once the last character is in
// the output register, even while it waits.
module signed_integer_radix_formatter_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [sirf_pkg::VALUE_WIDTH-1:0] value,
    input  logic [sirf_pkg::RADIX_WIDTH-1:0]       radix,
    input  logic [sirf_pkg::PREFIX_WIDTH-1:0]      prefix_kind,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [sirf_pkg::CHAR_WIDTH-1:0]        char_out,
    output logic                                   last_char
);
    import sirf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       idle;

    assign in_stall = !idle;

    sirf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .idle     (idle)
    );

    sirf_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value       (value),
        .radix       (radix),
        .prefix_kind (prefix_kind),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .last_char   (last_char)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("Block did not go busy after taking an item.");

    a_digit_from_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.sel == EMIT_DIGIT)) |-> !status.stack_empty)
        else $error("Digit emitted from an empty digit stack.");

    a_last_is_final_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |-> (cmd.emit && (cmd.sel == EMIT_DIGIT) && status.one_left))
        else $error("Last mark on a character that is not the final digit.");

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || !out_stall))
        else $error("Character written over a stalled output item.");

endmodule
